FILE: hw/rtl/cap_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the curvature-adaptive pen smoother.
// Depends on nothing; cap_isqrt, cap_divider, the top level and the testbench import it.
package cap_pkg;

    // Input commands.
    localparam logic [1:0] CMD_RESET    = 2'd0;
    localparam logic [1:0] CMD_SAMPLE   = 2'd1;
    localparam logic [1:0] CMD_POSITION = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    // Configuration register indexes.
    localparam logic REG_CORNER_SHARPNESS = 1'b0;
    localparam logic REG_LINE_SMOOTH      = 1'b1;
    localparam int   CFG_DATA_W           = 16;

    // Q16 constants.
    localparam logic [16:0] Q16_ONE    = 17'd65536;
    localparam logic [16:0] FACTOR_CAP = 17'd64225;
    localparam int          SCALE_BITS = 15;

    // Shared multiplier: the B operand is always a 16-bit value.
    localparam int MUL_B_W = 16;

    // Divider: 48-bit dividend, 32-bit divisor, 17-bit quotient.
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_Q_W   = 17;

    // Square root: 32-bit radicand, 16-bit root.
    localparam int SQ_IN_W  = 32;
    localparam int SQ_OUT_W = 16;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [SQ_IN_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic                done;
        logic [SQ_OUT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

FILE: hw/rtl/cap_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the pen smoother: samples in, positions out.
// Depends on nothing.
interface cap_sample_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [1:0]   command;
    logic [W-1:0] point_x;
    logic [W-1:0] point_y;

    modport source (output valid, command, point_x, point_y, input ready);
    modport sink   (input valid, command, point_x, point_y, output ready);
endinterface

interface cap_pos_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] pos_x;
    logic [W-1:0] pos_y;

    modport source (output valid, pos_x, pos_y, input ready);
    modport sink   (input valid, pos_x, pos_y, output ready);
endinterface

FILE: hw/rtl/cap_mul.sv
`timescale 1ns / 1ps
// Shared unsigned multiplier with a registered product.
// Depends on nothing.
module cap_mul #(
    parameter int A_W = 24,
    parameter int B_W = 16
) (
    input  logic             clk,
    input  logic [A_W-1:0]   a,
    input  logic [B_W-1:0]   b,
    output logic [A_W+B_W-1:0] p
);
    always_ff @(posedge clk)
    begin
        p <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end
endmodule

FILE: hw/rtl/cap_isqrt.sv
`timescale 1ns / 1ps
// Floor square root, two radicand bits per cycle.
// Depends on cap_pkg.
module cap_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  cap_pkg::sqrt_req_t req,
    output cap_pkg::sqrt_rsp_t rsp
);
    import cap_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [4:0]          cnt_reg;
    logic [SQ_IN_W-1:0]  rad_reg;
    logic [SQ_OUT_W+2:0] rem_reg;
    logic [SQ_OUT_W-1:0] root_reg;

    logic [SQ_OUT_W+2:0] rem_shift;
    logic [SQ_OUT_W+2:0] trial;
    logic                fits;

    assign rem_shift = {rem_reg[SQ_OUT_W:0], rad_reg[SQ_IN_W-1 -: 2]};
    assign trial     = (SQ_OUT_W+3)'({root_reg, 2'b01});
    assign fits      = rem_shift >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(SQ_OUT_W);
                rad_reg  <= req.radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                rad_reg <= rad_reg << 2;
                if (fits)
                begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[SQ_OUT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[SQ_OUT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;
endmodule

FILE: hw/rtl/cap_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// The caller guarantees that the quotient fits in 17 bits. Depends on cap_pkg.
module cap_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  cap_pkg::div_req_t req,
    output cap_pkg::div_rsp_t rsp
);
    import cap_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [4:0]           cnt_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_Q_W-1:0]   low_reg;
    logic [DIV_Q_W-1:0]   quot_reg;

    logic [DIV_DEN_W:0]   rem_shift;
    logic                 fits;

    assign rem_shift = {rem_reg, low_reg[DIV_Q_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            low_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(DIV_Q_W);
                den_reg  <= req.den;
                rem_reg  <= DIV_DEN_W'(req.num[DIV_NUM_W-1:DIV_Q_W]);
                low_reg  <= req.num[DIV_Q_W-1:0];
                quot_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= DIV_DEN_W'(rem_shift - {1'b0, den_reg});
                end
                else
                begin
                    rem_reg <= DIV_DEN_W'(rem_shift);
                end
                quot_reg <= {quot_reg[DIV_Q_W-2:0], fits};
                low_reg  <= low_reg << 1;
                cnt_reg  <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
endmodule

FILE: hw/rtl/curvature_adaptive_pen_smoother.sv
`timescale 1ns / 1ps
// Curvature-adaptive pen smoother, top level. Depends on cap_pkg, cap_if, cap_mul,
// cap_isqrt and cap_divider. Reset, set-position, unused and first-sample transactions
// go straight from acceptance to the result stage; the next one is taken once that result is handed on.
// A sample with two long segments shifts each right until it fits below 2^15 (at most 17
// shift bits) and takes two 16-step roots; up to two 17-step divisions; one at a time.
// rst_n clears position, history, registers (sharpness 2.0, smoothing 0.5) at once.
module curvature_adaptive_pen_smoother #(
    parameter int COORD_WIDTH     = 32,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [cap_pkg::CFG_DATA_W-1:0] cfg_data,
    cap_sample_if.sink                    sample,
    cap_pos_if.source                     position
);
    import cap_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int V_W   = COORD_WIDTH + 1;
    localparam int MA_W  = (COORD_WIDTH - 15 > 24) ? COORD_WIDTH - 15 : 24;
    localparam int P_W   = MA_W + MUL_B_W;
    localparam int ACC_W = P_W + 2;
    localparam logic [63:0] LONG_LIM = (64'd1 << (2 * COORD_FRAC_BITS)) / 64'd10000;

    localparam logic [5:0] ST_IDLE    = 6'd0;
    localparam logic [5:0] ST_SQ_AX   = 6'd1;
    localparam logic [5:0] ST_SQ_AY   = 6'd2;
    localparam logic [5:0] ST_SQ_BX   = 6'd3;
    localparam logic [5:0] ST_SQ_BY   = 6'd4;
    localparam logic [5:0] ST_LONG_B  = 6'd5;
    localparam logic [5:0] ST_SCALE   = 6'd6;
    localparam logic [5:0] ST_LA0     = 6'd7;
    localparam logic [5:0] ST_LA1     = 6'd8;
    localparam logic [5:0] ST_LB0     = 6'd9;
    localparam logic [5:0] ST_LB1     = 6'd10;
    localparam logic [5:0] ST_D0      = 6'd11;
    localparam logic [5:0] ST_D1      = 6'd12;
    localparam logic [5:0] ST_D2      = 6'd13;
    localparam logic [5:0] ST_SQA_GO  = 6'd14;
    localparam logic [5:0] ST_SQA_W   = 6'd15;
    localparam logic [5:0] ST_SQB_GO  = 6'd16;
    localparam logic [5:0] ST_SQB_W   = 6'd17;
    localparam logic [5:0] ST_LL0     = 6'd18;
    localparam logic [5:0] ST_LL1     = 6'd19;
    localparam logic [5:0] ST_QDIV_W  = 6'd20;
    localparam logic [5:0] ST_THR     = 6'd21;
    localparam logic [5:0] ST_FMUL    = 6'd22;
    localparam logic [5:0] ST_FDIV_W  = 6'd23;
    localparam logic [5:0] ST_BX0     = 6'd24;
    localparam logic [5:0] ST_BX1     = 6'd25;
    localparam logic [5:0] ST_BX2     = 6'd26;
    localparam logic [5:0] ST_BY0     = 6'd27;
    localparam logic [5:0] ST_BY1     = 6'd28;
    localparam logic [5:0] ST_BY2     = 6'd29;
    localparam logic [5:0] ST_DONE    = 6'd30;

    logic [5:0]    state_reg;
    logic [15:0]   sharp_reg;
    logic [15:0]   smooth_reg;
    logic [W-1:0]  out_x_reg, out_y_reg;
    logic [W-1:0]  last_x_reg, last_y_reg;
    logic [W-1:0]  older_x_reg, older_y_reg;
    logic          hist_valid_reg;
    logic [W-1:0]  px_reg, py_reg;
    logic [V_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic          sax_reg, say_reg, sbx_reg, sby_reg;
    logic          long_a_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [31:0]   sq_a_reg, sq_b_reg;
    logic [31:0]   dot_mag_reg;
    logic          dot_neg_reg;
    logic [15:0]   l1_reg;
    logic [17:0]   c_reg;
    logic [15:0]   w_reg;
    logic          pos_valid_reg;
    logic [W-1:0]  pos_x_reg, pos_y_reg;

    logic [MA_W-1:0]    mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [P_W-1:0]     prod;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    sqrt_req_t          sq_req;
    sqrt_rsp_t          sq_rsp;

    cap_mul #(.A_W(MA_W), .B_W(MUL_B_W)) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    cap_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    cap_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Segment vectors formed at acceptance.
    logic [V_W-1:0] p_x_ext, p_y_ext, last_x_ext, last_y_ext, older_x_ext, older_y_ext;
    logic [V_W-1:0] v1x, v1y, v2x, v2y;

    assign p_x_ext     = {sample.point_x[W-1], sample.point_x};
    assign p_y_ext     = {sample.point_y[W-1], sample.point_y};
    assign last_x_ext  = {last_x_reg[W-1], last_x_reg};
    assign last_y_ext  = {last_y_reg[W-1], last_y_reg};
    assign older_x_ext = {older_x_reg[W-1], older_x_reg};
    assign older_y_ext = {older_y_reg[W-1], older_y_reg};
    assign v1x = last_x_ext - older_x_ext;
    assign v1y = last_y_ext - older_y_ext;
    assign v2x = p_x_ext - last_x_ext;
    assign v2y = p_y_ext - last_y_ext;

    function automatic logic [V_W-1:0] magnitude(input logic [V_W-1:0] v);
        magnitude = v[V_W-1] ? (~v + V_W'(1)) : v;
    endfunction

    // Segment length and scaling tests.
    logic big_a, big_b, need_a, need_b;
    logic [ACC_W-1:0] sum_sq;

    assign big_a  = ((ax_reg >> COORD_FRAC_BITS) != '0) || ((ay_reg >> COORD_FRAC_BITS) != '0);
    assign big_b  = ((bx_reg >> COORD_FRAC_BITS) != '0) || ((by_reg >> COORD_FRAC_BITS) != '0);
    assign need_a = ((ax_reg >> SCALE_BITS) != '0) || ((ay_reg >> SCALE_BITS) != '0);
    assign need_b = ((bx_reg >> SCALE_BITS) != '0) || ((by_reg >> SCALE_BITS) != '0);
    assign sum_sq = acc_reg + ACC_W'(prod);

    logic [ACC_W-1:0] prod_signed_x, prod_signed_y, dot_sum;
    assign prod_signed_x = (sax_reg ^ sbx_reg) ? (~ACC_W'(prod) + ACC_W'(1)) : ACC_W'(prod);
    assign prod_signed_y = (say_reg ^ sby_reg) ? (~ACC_W'(prod) + ACC_W'(1)) : ACC_W'(prod);
    assign dot_sum       = acc_reg + prod_signed_y;

    // Cosine quotient overflow: the quotient reaches 2^17 and is capped anyway.
    logic [DIV_NUM_W-1:0] cos_num;
    logic                 cos_ovf;
    assign cos_num = {dot_mag_reg, 16'h0000};
    assign cos_ovf = {1'b0, cos_num} >= {prod[31:0], 17'h00000};

    logic [16:0] q_capped;
    assign q_capped = (div_rsp.quot > Q16_ONE) ? Q16_ONE : div_rsp.quot;

    // Threshold and factor.
    logic [23:0] thresh;
    logic [23:0] c5;
    logic        corner;
    logic [16:0] factor;
    assign thresh = {sharp_reg, 8'h00};
    assign c5     = 24'({c_reg, 2'b00}) + 24'(c_reg);
    assign corner = c5 >= thresh;
    assign factor = (div_rsp.quot > FACTOR_CAP) ? FACTOR_CAP : div_rsp.quot;

    // Blend toward the target.
    logic [V_W-1:0] diff_x, diff_y, m_x, m_y;
    logic [ACC_W-1:0] step, out_x_ext, out_y_ext, new_x, new_y;
    assign diff_x    = {px_reg[W-1], px_reg} - {out_x_reg[W-1], out_x_reg};
    assign diff_y    = {py_reg[W-1], py_reg} - {out_y_reg[W-1], out_y_reg};
    assign m_x       = magnitude(diff_x);
    assign m_y       = magnitude(diff_y);
    assign step      = acc_reg + ACC_W'((prod + P_W'(32768)) >> 16);
    assign out_x_ext = ACC_W'(signed'(out_x_reg));
    assign out_y_ext = ACC_W'(signed'(out_y_reg));
    assign new_x     = diff_x[V_W-1] ? out_x_ext - step : out_x_ext + step;
    assign new_y     = diff_y[V_W-1] ? out_y_ext - step : out_y_ext + step;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ_AX, ST_LA0:
            begin
                mul_a = MA_W'(ax_reg);
                mul_b = ax_reg[MUL_B_W-1:0];
            end
            ST_SQ_AY, ST_LA1:
            begin
                mul_a = MA_W'(ay_reg);
                mul_b = ay_reg[MUL_B_W-1:0];
            end
            ST_SQ_BX, ST_LB0:
            begin
                mul_a = MA_W'(bx_reg);
                mul_b = bx_reg[MUL_B_W-1:0];
            end
            ST_SQ_BY, ST_LB1:
            begin
                mul_a = MA_W'(by_reg);
                mul_b = by_reg[MUL_B_W-1:0];
            end
            ST_D0:
            begin
                mul_a = MA_W'(ax_reg);
                mul_b = bx_reg[MUL_B_W-1:0];
            end
            ST_D1:
            begin
                mul_a = MA_W'(ay_reg);
                mul_b = by_reg[MUL_B_W-1:0];
            end
            ST_LL0:
            begin
                mul_a = MA_W'(l1_reg);
                mul_b = sq_rsp.root;
            end
            ST_THR:
            begin
                mul_a = MA_W'(thresh - c5);
                mul_b = smooth_reg;
            end
            ST_BX0:
            begin
                mul_a = MA_W'(m_x >> 16);
                mul_b = w_reg;
            end
            ST_BX1:
            begin
                mul_a = MA_W'(m_x[15:0]);
                mul_b = w_reg;
            end
            ST_BY0:
            begin
                mul_a = MA_W'(m_y >> 16);
                mul_b = w_reg;
            end
            ST_BY1:
            begin
                mul_a = MA_W'(m_y[15:0]);
                mul_b = w_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        sq_req.start    = (state_reg == ST_SQA_GO) || (state_reg == ST_SQB_GO);
        sq_req.radicand = (state_reg == ST_SQA_GO) ? sq_a_reg : sq_b_reg;
    end

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = cos_num;
        div_req.den   = prod[31:0];
        if ((state_reg == ST_LL1) && (l1_reg != '0) && (sq_rsp.root != '0) && !cos_ovf)
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == ST_FMUL)
        begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(prod);
            div_req.den   = DIV_DEN_W'(thresh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sharp_reg  <= 16'd512;
            smooth_reg <= 16'd32768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CORNER_SHARPNESS: sharp_reg  <= cfg_data;
                REG_LINE_SMOOTH:      smooth_reg <= cfg_data;
                default:              sharp_reg  <= sharp_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            older_x_reg    <= '0;
            older_y_reg    <= '0;
            hist_valid_reg <= 1'b0;
            px_reg         <= '0;
            py_reg         <= '0;
            ax_reg         <= '0;
            ay_reg         <= '0;
            bx_reg         <= '0;
            by_reg         <= '0;
            sax_reg        <= 1'b0;
            say_reg        <= 1'b0;
            sbx_reg        <= 1'b0;
            sby_reg        <= 1'b0;
            long_a_reg     <= 1'b0;
            acc_reg        <= '0;
            sq_a_reg       <= '0;
            sq_b_reg       <= '0;
            dot_mag_reg    <= '0;
            dot_neg_reg    <= 1'b0;
            l1_reg         <= '0;
            c_reg          <= '0;
            w_reg          <= '0;
            pos_valid_reg  <= 1'b0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
        end
        else
        begin
            if (position.ready && (state_reg != ST_DONE))
            begin
                pos_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample.valid)
                    begin
                        state_reg <= ST_DONE;
                        px_reg    <= sample.point_x;
                        py_reg    <= sample.point_y;
                        priority case (sample.command)
                            CMD_RESET:
                            begin
                                out_x_reg      <= sample.point_x;
                                out_y_reg      <= sample.point_y;
                                last_x_reg     <= sample.point_x;
                                last_y_reg     <= sample.point_y;
                                older_x_reg    <= sample.point_x;
                                older_y_reg    <= sample.point_y;
                                hist_valid_reg <= 1'b0;
                            end
                            CMD_POSITION:
                            begin
                                out_x_reg <= sample.point_x;
                                out_y_reg <= sample.point_y;
                            end
                            CMD_SAMPLE:
                            begin
                                older_x_reg <= last_x_reg;
                                older_y_reg <= last_y_reg;
                                last_x_reg  <= sample.point_x;
                                last_y_reg  <= sample.point_y;
                                if (!hist_valid_reg)
                                begin
                                    out_x_reg      <= sample.point_x;
                                    out_y_reg      <= sample.point_y;
                                    hist_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    ax_reg    <= magnitude(v1x);
                                    ay_reg    <= magnitude(v1y);
                                    bx_reg    <= magnitude(v2x);
                                    by_reg    <= magnitude(v2y);
                                    sax_reg   <= v1x[V_W-1];
                                    say_reg   <= v1y[V_W-1];
                                    sbx_reg   <= v2x[V_W-1];
                                    sby_reg   <= v2y[V_W-1];
                                    state_reg <= ST_SQ_AX;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SQ_AX:
                begin
                    state_reg <= ST_SQ_AY;
                end
                ST_SQ_AY:
                begin
                    acc_reg   <= ACC_W'(prod);
                    state_reg <= ST_SQ_BX;
                end
                ST_SQ_BX:
                begin
                    long_a_reg <= big_a || (sum_sq > ACC_W'(LONG_LIM));
                    state_reg  <= ST_SQ_BY;
                end
                ST_SQ_BY:
                begin
                    acc_reg   <= ACC_W'(prod);
                    state_reg <= ST_LONG_B;
                end
                ST_LONG_B:
                begin
                    if (long_a_reg && (big_b || (sum_sq > ACC_W'(LONG_LIM))))
                    begin
                        state_reg <= ST_SCALE;
                    end
                    else
                    begin
                        c_reg     <= '0;
                        state_reg <= ST_THR;
                    end
                end
                ST_SCALE:
                begin
                    // One bit of right shift per cycle until both segments fit 15 bits.
                    if (need_a)
                    begin
                        ax_reg <= ax_reg >> 1;
                        ay_reg <= ay_reg >> 1;
                    end
                    if (need_b)
                    begin
                        bx_reg <= bx_reg >> 1;
                        by_reg <= by_reg >> 1;
                    end
                    if (!need_a && !need_b)
                    begin
                        state_reg <= ST_LA0;
                    end
                end
                ST_LA0:
                begin
                    state_reg <= ST_LA1;
                end
                ST_LA1:
                begin
                    acc_reg   <= ACC_W'(prod);
                    state_reg <= ST_LB0;
                end
                ST_LB0:
                begin
                    sq_a_reg  <= sum_sq[31:0];
                    state_reg <= ST_LB1;
                end
                ST_LB1:
                begin
                    acc_reg   <= ACC_W'(prod);
                    state_reg <= ST_D0;
                end
                ST_D0:
                begin
                    sq_b_reg  <= sum_sq[31:0];
                    state_reg <= ST_D1;
                end
                ST_D1:
                begin
                    acc_reg   <= prod_signed_x;
                    state_reg <= ST_D2;
                end
                ST_D2:
                begin
                    dot_neg_reg <= dot_sum[ACC_W-1];
                    dot_mag_reg <= dot_sum[ACC_W-1] ? 32'(~dot_sum + ACC_W'(1)) : dot_sum[31:0];
                    state_reg   <= ST_SQA_GO;
                end
                ST_SQA_GO:
                begin
                    state_reg <= ST_SQA_W;
                end
                ST_SQA_W:
                begin
                    if (sq_rsp.done)
                    begin
                        l1_reg    <= sq_rsp.root;
                        state_reg <= ST_SQB_GO;
                    end
                end
                ST_SQB_GO:
                begin
                    state_reg <= ST_SQB_W;
                end
                ST_SQB_W:
                begin
                    if (sq_rsp.done)
                    begin
                        state_reg <= ST_LL0;
                    end
                end
                ST_LL0:
                begin
                    state_reg <= ST_LL1;
                end
                ST_LL1:
                begin
                    if ((l1_reg == '0) || (sq_rsp.root == '0))
                    begin
                        c_reg     <= '0;
                        state_reg <= ST_THR;
                    end
                    else if (cos_ovf)
                    begin
                        c_reg     <= dot_neg_reg ? 18'({Q16_ONE, 1'b0}) : 18'd0;
                        state_reg <= ST_THR;
                    end
                    else
                    begin
                        state_reg <= ST_QDIV_W;
                    end
                end
                ST_QDIV_W:
                begin
                    if (div_rsp.done)
                    begin
                        c_reg     <= dot_neg_reg ? 18'(Q16_ONE) + 18'(q_capped)
                                                 : 18'(Q16_ONE) - 18'(q_capped);
                        state_reg <= ST_THR;
                    end
                end
                ST_THR:
                begin
                    if (corner)
                    begin
                        out_x_reg <= px_reg;
                        out_y_reg <= py_reg;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_FMUL;
                    end
                end
                ST_FMUL:
                begin
                    state_reg <= ST_FDIV_W;
                end
                ST_FDIV_W:
                begin
                    if (div_rsp.done)
                    begin
                        if (factor == '0)
                        begin
                            out_x_reg <= px_reg;
                            out_y_reg <= py_reg;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            w_reg     <= 16'(Q16_ONE - factor);
                            state_reg <= ST_BX0;
                        end
                    end
                end
                ST_BX0:
                begin
                    state_reg <= ST_BX1;
                end
                ST_BX1:
                begin
                    acc_reg   <= ACC_W'(prod);
                    state_reg <= ST_BX2;
                end
                ST_BX2:
                begin
                    out_x_reg <= new_x[W-1:0];
                    state_reg <= ST_BY0;
                end
                ST_BY0:
                begin
                    state_reg <= ST_BY1;
                end
                ST_BY1:
                begin
                    acc_reg   <= ACC_W'(prod);
                    state_reg <= ST_BY2;
                end
                ST_BY2:
                begin
                    out_y_reg <= new_y[W-1:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // Hand the position to the output register once it is free.
                    if (!pos_valid_reg || position.ready)
                    begin
                        pos_valid_reg <= 1'b1;
                        pos_x_reg     <= out_x_reg;
                        pos_y_reg     <= out_y_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sample.ready   = (state_reg == ST_IDLE);
    assign position.valid = pos_valid_reg;
    assign position.pos_x = pos_x_reg;
    assign position.pos_y = pos_y_reg;

`ifndef NO_ASSERTIONS
    a_simple_cmd_done: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready && (sample.command != CMD_SAMPLE)) |=> state_reg == ST_DONE)
        else $error("non-sample transaction did not go straight to the result stage");

    a_scaled_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LA0) |-> (!need_a && !need_b))
        else $error("segment not scaled below 2^15 before the length pass");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(position.valid) |-> $past(state_reg) == ST_DONE)
        else $error("result presented outside the result stage");

    a_curv_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_THR) |-> c_reg <= 18'({Q16_ONE, 1'b0}))
        else $error("curvature above 2.0");
`endif
endmodule

FILE: sim/pen_smoother_checker.sv
`timescale 1ns / 1ps
// Checker for the curvature-adaptive pen smoother: watches the sample and position
// channels and the register port, predicts every position and compares. Uses cap_pkg.
module pen_smoother_checker
    import cap_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [1:0]            in_command,
    input  logic [31:0]           in_x,
    input  logic [31:0]           in_y,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [31:0]           out_x,
    input  logic [31:0]           out_y,
    output int                    fail_count,
    output int                    pending
);

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
    } pos_t;

    pos_t expected_pos[$];

    logic [15:0]        sharpness;
    logic [15:0]        smooth;
    logic signed [63:0] cur_x, cur_y, last_x, last_y, older_x, older_y;
    logic               have_history;

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic is_long(input logic signed [63:0] vx, input logic signed [63:0] vy);
        logic [63:0] ax, ay;
        ax = magnitude(vx);
        ay = magnitude(vy);
        if (ax >= 256 || ay >= 256)
            return 1'b1;
        return (ax * ax + ay * ay) * 10000 > 64'd65536;
    endfunction

    function automatic void shrink(inout logic signed [63:0] vx, inout logic signed [63:0] vy);
        logic [63:0] ax, ay, mx;
        int          s;
        ax = magnitude(vx);
        ay = magnitude(vy);
        mx = ax > ay ? ax : ay;
        s = 0;
        while ((mx >> s) >= 32768)
            s++;
        ax = ax >> s;
        ay = ay >> s;
        vx = vx < 0 ? -$signed(ax) : $signed(ax);
        vy = vy < 0 ? -$signed(ay) : $signed(ay);
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
                r = r | (64'd1 << b);
        return r;
    endfunction

    function automatic logic [63:0] bend(input logic signed [63:0] ax, input logic signed [63:0] ay,
                                         input logic signed [63:0] bx, input logic signed [63:0] by);
        logic signed [63:0] dot;
        logic [63:0]        l1, l2, q;
        if (!is_long(ax, ay) || !is_long(bx, by))
            return 0;
        shrink(ax, ay);
        shrink(bx, by);
        dot = ax * bx + ay * by;
        l1 = floor_root(ax * ax + ay * ay);
        l2 = floor_root(bx * bx + by * by);
        if (l1 == 0 || l2 == 0)
            return 0;
        q = (magnitude(dot) << 16) / (l1 * l2);
        if (q > 65536)
            q = 65536;
        return dot < 0 ? 65536 + q : 65536 - q;
    endfunction

    function automatic logic signed [63:0] approach(input logic signed [63:0] p,
                                                    input logic signed [63:0] t,
                                                    input logic [63:0] w);
        logic signed [63:0] d;
        logic [63:0]        m, step;
        if (w >= 65536)
            return t;
        d = t - p;
        m = magnitude(d);
        step = (m >> 16) * w + (((m & 64'hFFFF) * w + 32768) >> 16);
        return d < 0 ? p - $signed(step) : p + $signed(step);
    endfunction

    function automatic logic signed [63:0] wrap32(input logic signed [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    task automatic predict_position(input logic [1:0] cmd, input logic [31:0] px32,
                                    input logic [31:0] py32);
        logic signed [63:0] px, py;
        logic [63:0]        c, t, f;
        pos_t               p;
        px = {{32{px32[31]}}, px32};
        py = {{32{py32[31]}}, py32};
        if (cmd == CMD_RESET)
        begin
            cur_x = px; older_x = px; last_x = px;
            cur_y = py; older_y = py; last_y = py;
            have_history = 1'b0;
        end
        else if (cmd == CMD_POSITION)
        begin
            cur_x = px;
            cur_y = py;
        end
        else if (cmd == CMD_SAMPLE)
        begin
            if (!have_history)
            begin
                cur_x = px;
                cur_y = py;
                have_history = 1'b1;
            end
            else
            begin
                c = bend(last_x - older_x, last_y - older_y, px - last_x, py - last_y);
                t = 64'(sharpness) * 256;
                f = 0;
                if (5 * c < t)
                begin
                    f = 64'(smooth) * (t - 5 * c) / t;
                    if (f > FACTOR_CAP)
                        f = FACTOR_CAP;
                end
                cur_x = wrap32(approach(cur_x, px, 65536 - f));
                cur_y = wrap32(approach(cur_y, py, 65536 - f));
            end
            older_x = last_x; older_y = last_y;
            last_x = px;      last_y = py;
        end
        p.x = cur_x[31:0];
        p.y = cur_y[31:0];
        expected_pos.push_back(p);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sharpness    = 16'd512;
            smooth       = 16'd32768;
            cur_x = 0; cur_y = 0; last_x = 0; last_y = 0; older_x = 0; older_y = 0;
            have_history = 1'b0;
            fail_count   = 0;
            expected_pos.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_CORNER_SHARPNESS)
                    sharpness = cfg_data;
                else
                    smooth = cfg_data;
            end
            if (in_valid && in_ready)
                predict_position(in_command, in_x, in_y);
            if (out_valid && out_ready)
            begin
                if (expected_pos.size() == 0)
                begin
                    $error("position with no transaction pending: %h %h", out_x, out_y);
                    fail_count++;
                end
                else
                begin
                    pos_t e;
                    e = expected_pos.pop_front();
                    if (e.x !== out_x)
                    begin
                        $error("pos_x expected %h actual %h", e.x, out_x);
                        fail_count++;
                    end
                    if (e.y !== out_y)
                    begin
                        $error("pos_y expected %h actual %h", e.y, out_y);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_pos.size();
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Top of the pen smoother testbench: drives samples, register writes and backpressure,
// and gives the verdict. Depends on cap_pkg, cap_if, the block and pen_smoother_checker.
module tb_top;
    import cap_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    send_idle;
    int                    stall_pct;
    int                    hold_cycles;
    int                    hold_req;
    int                    hold_ack;
    logic signed [31:0]    walk_x, walk_y;

    cap_sample_if #(32) sample ();
    cap_pos_if    #(32) position ();

    curvature_adaptive_pen_smoother i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .sample   (sample),
        .position (position)
    );

    pen_smoother_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .in_command(sample.command),
        .in_x      (sample.point_x),
        .in_y      (sample.point_y),
        .out_valid (position.valid),
        .out_ready (position.ready),
        .out_x     (position.pos_x),
        .out_y     (position.pos_y),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Receiver: random stalls, or a long hold-off counted in cycles once requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position.ready <= 1'b0;
            hold_cycles    <= 0;
            hold_ack       <= 0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack       <= hold_req;
            hold_cycles    <= 600;
            position.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles    <= hold_cycles - 1;
            position.ready <= 1'b0;
        end
        else
            position.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits for all positions, then past the longest sample latency.
    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic send(input logic [1:0] cmd, input logic [31:0] px, input logic [31:0] py);
        while ($urandom_range(99) < send_idle)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid   <= 1'b1;
        sample.command <= cmd;
        sample.point_x <= px;
        sample.point_y <= py;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
    endtask

    task automatic idle_input();
        sample.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly a pen stroke: small steps with occasional turns and big jumps.
    task automatic random_item();
        int          r;
        logic [31:0] dx, dy;
        r = $urandom_range(99);
        if (r < 3)
            send(CMD_RESET, $urandom, $urandom);
        else if (r < 6)
            send(CMD_POSITION, $urandom, $urandom);
        else if (r < 8)
            send(CMD_UNUSED, $urandom, $urandom);
        else if (r < 14)
            send(CMD_SAMPLE, $urandom, $urandom);
        else
        begin
            dx = $urandom_range(8) == 0 ? $urandom_range(3) : $urandom_range(4095);
            dy = $urandom_range(8) == 0 ? $urandom_range(3) : $urandom_range(4095);
            if ($urandom_range(1)) dx = -dx;
            if ($urandom_range(1)) dy = -dy;
            if ($urandom_range(30) == 0)
                dx = $urandom;
            walk_x = walk_x + dx;
            walk_y = walk_y + dy;
            send(CMD_SAMPLE, walk_x, walk_y);
        end
    endtask

    initial
    begin
        logic [15:0] sharp_set[5];
        logic [15:0] smooth_set[5];
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = 1'b0;
        cfg_data       = '0;
        sample.valid   = 1'b0;
        sample.command = CMD_RESET;
        sample.point_x = '0;
        sample.point_y = '0;
        send_idle      = 0;
        stall_pct      = 0;
        hold_req       = 0;
        walk_x         = 0;
        walk_y         = 0;
        sharp_set  = '{16'd512, 16'd0, 16'd65535, 16'd40, 16'd1};
        smooth_set = '{16'd32768, 16'd65535, 16'd0, 16'd60000, 16'd1};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first sample, straight line, corner, reversal, tiny steps,
        // extreme coordinates, every command including the unused one.
        send(CMD_SAMPLE, 32'd1000, 32'd0);
        send(CMD_SAMPLE, 32'd2000, 32'd0);
        send(CMD_SAMPLE, 32'd3000, 32'd0);
        send(CMD_SAMPLE, 32'd3000, 32'd1000);
        send(CMD_SAMPLE, 32'd1000, 32'd1000);
        send(CMD_SAMPLE, 32'd1001, 32'd1001);
        send(CMD_SAMPLE, 32'd1003, 32'd1000);
        send(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000);
        send(CMD_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
        send(CMD_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0001);
        send(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_POSITION, 32'h8000_0000, 32'h8000_0000);
        send(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(CMD_RESET, 32'h7FFF_FFFF, 32'h8000_0000);
        send(CMD_SAMPLE, 32'h7FFF_FF00, 32'h8000_0100);
        send(CMD_SAMPLE, 32'h7FFF_FE00, 32'h8000_0200);
        send(CMD_SAMPLE, 32'h7FFF_FE01, 32'h8000_0200);
        idle_input();
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_CORNER_SHARPNESS, sharp_set[phase]);
            write_reg(REG_LINE_SMOOTH, smooth_set[phase]);
            case (phase % 4)
                0: begin send_idle = 0;  stall_pct = 0;  end
                1: begin send_idle = 70; stall_pct = 0;  end
                2: begin send_idle = 0;  stall_pct = 70; end
                default: begin send_idle = 23; stall_pct = 23; end
            endcase
            if (phase == 0)
                hold_req = hold_req + 1;
            for (int n = 0; n < 130; n++)
                random_item();
            idle_input();
            drain();
        end

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/cap_pkg.sv
hw/rtl/cap_if.sv
hw/rtl/cap_mul.sv
hw/rtl/cap_isqrt.sv
hw/rtl/cap_divider.sv
hw/rtl/curvature_adaptive_pen_smoother.sv
sim/pen_smoother_checker.sv
sim/tb_top.sv
